### rtl/pcsh_pkg.sv
// shared types, codes and helpers for the profile counter histogram
package pcsh_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned VAL_W        = 64;
  localparam int unsigned BUCKET_IDX_W = 8;
  localparam int unsigned STATUS_W     = 4;
  localparam int unsigned OPCODE_W     = 2;
  localparam int unsigned IN_DATA_W    = 40;
  localparam int unsigned OUT_DATA_W   = 328;
  localparam int unsigned FIFO_DEPTH   = 3;
  localparam int unsigned LEVEL_W      = 2;

  localparam logic [WORD_W-1:0] FILE_MAGIC   = 32'h6763_6461;
  localparam logic [WORD_W-1:0] TAG_FUNC     = 32'h0100_0000;
  localparam logic [WORD_W-1:0] TAG_COUNTERS = 32'h01a1_0000;
  localparam logic [VAL_W-1:0]  MIN_EMPTY    = 64'h7fff_ffff_ffff_ffff;
  localparam int unsigned       TAG_SHIFT    = 17;
  localparam logic [WORD_W-1:0] TAG_SPAN     = 32'd9;

  localparam logic [OPCODE_W-1:0] OP_STREAM = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK          = 4'd0;
  localparam logic [STATUS_W-1:0] ST_ACCEPTED    = 4'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_MAGIC   = 4'd2;
  localparam logic [STATUS_W-1:0] ST_LONE_TAG    = 4'd3;
  localparam logic [STATUS_W-1:0] ST_ODD_LENGTH  = 4'd4;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN_TAG = 4'd5;
  localparam logic [STATUS_W-1:0] ST_OVERRUN     = 4'd6;
  localparam logic [STATUS_W-1:0] ST_IN_COUNTERS = 4'd7;
  localparam logic [STATUS_W-1:0] ST_DROPPED     = 4'd8;

  typedef enum logic [6:0] {
    PH_MAGIC   = 7'b000_0001,
    PH_SKIP    = 7'b000_0010,
    PH_TAG     = 7'b000_0100,
    PH_LENSKIP = 7'b000_1000,
    PH_CTRLEN  = 7'b001_0000,
    PH_CTRLO   = 7'b010_0000,
    PH_CTRHI   = 7'b100_0000
  } phase_t;

  typedef struct packed {
    logic [31:0]      tally;
    logic [VAL_W-1:0] least;
    logic [VAL_W-1:0] total;
  } bucket_t;

  typedef struct packed {
    logic                    insert;
    logic                    read;
    logic [BUCKET_IDX_W-1:0] idx;
    logic [VAL_W-1:0]        value;
  } store_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [31:0]         total_count;
    logic [VAL_W-1:0]    total_sum;
    logic [VAL_W-1:0]    max_value;
  } parse_res_t;

  function automatic logic less_signed(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // position of the leading one, zero for a zero word
  function automatic logic [4:0] msb_pos32(input logic [WORD_W-1:0] w);
    logic [4:0] pos;
    pos = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) pos = 5'(i);
    end
    return pos;
  endfunction

endpackage

### rtl/pcsh_parser.sv
// file word parser, running totals and bucket request generation
module pcsh_parser
  import pcsh_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [OPCODE_W-1:0]     opcode,
  input  logic [WORD_W-1:0]       word,
  input  logic                    file_end,
  input  logic [BUCKET_IDX_W-1:0] bucket_index,
  output store_req_t              req,
  output logic                    clear_all,
  output parse_res_t              res
);

  phase_t            phase, phase_next;
  logic [WORD_W-1:0] skip, skip_next;
  logic [30:0]       pairs, pairs_next;
  logic [WORD_W-1:0] low_half, low_half_next;
  logic [4:0]        lo_pos, lo_pos_next;
  logic              lo_nz, lo_nz_next;
  logic              err, err_next;
  logic [31:0]       cnt, cnt_next;
  logic [VAL_W-1:0]  sum, sum_next;
  logic [VAL_W-1:0]  largest, largest_next;
  logic [STATUS_W-1:0] status;

  logic [WORD_W-1:0] skip_dec;
  logic [30:0]       pairs_dec;
  logic [30:0]       half_len;
  logic [WORD_W-1:0] tag_off;
  logic              tag_known;
  logic [VAL_W-1:0]  value;
  logic [5:0]        lead;
  logic [5:0]        lead_m1;
  logic [5:0]        lead_m2;
  logic [BUCKET_IDX_W-1:0] ins_idx;

  assign skip_dec  = (skip != '0) ? skip - 32'd1 : '0;
  assign pairs_dec = (pairs != '0) ? pairs - 31'd1 : '0;
  assign half_len  = word[31:1];
  assign tag_off   = word - TAG_COUNTERS;
  assign tag_known = (word[15:0] == 16'h0000) && ((tag_off >> TAG_SHIFT) < TAG_SPAN);
  assign value     = {word, low_half};

  always_comb begin
    if (word != '0) begin
      lead = {1'b1, msb_pos32(word)};
    end else if (lo_nz) begin
      lead = {1'b0, lo_pos};
    end else begin
      lead = '0;
    end
    lead_m1 = lead - 6'd1;
    lead_m2 = lead - 6'd2;
    if (lead < 6'd2) begin
      ins_idx = {6'd0, low_half[1:0]};
    end else begin
      ins_idx = {lead_m1, value[lead_m1], value[lead_m2]};
    end
  end

  always_comb begin
    phase_next    = phase;
    skip_next     = skip;
    pairs_next    = pairs;
    low_half_next = low_half;
    lo_pos_next   = lo_pos;
    lo_nz_next    = lo_nz;
    err_next      = err;
    cnt_next      = cnt;
    sum_next      = sum;
    largest_next  = largest;
    status        = ST_OK;
    req           = '0;
    clear_all     = 1'b0;
    if (accept) begin
      unique case (opcode)
        OP_STREAM: begin
          if (err) begin
            if (file_end) begin
              err_next   = 1'b0;
              phase_next = PH_MAGIC;
            end
            status = ST_DROPPED;
          end else begin
            unique case (phase)
              PH_MAGIC: begin
                if (word != FILE_MAGIC) begin
                  status = ST_BAD_MAGIC;
                  if (!file_end) err_next = 1'b1;
                end else if (file_end) begin
                  status = ST_OVERRUN;
                end else begin
                  skip_next  = 32'd2;
                  phase_next = PH_SKIP;
                end
              end
              PH_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                  phase_next = PH_TAG;
                  if (file_end) begin
                    phase_next = PH_MAGIC;
                    status     = ST_ACCEPTED;
                  end
                end else if (file_end) begin
                  phase_next = PH_MAGIC;
                  status     = ST_OVERRUN;
                end
              end
              PH_TAG: begin
                if (word == '0) begin
                  if (file_end) begin
                    phase_next = PH_MAGIC;
                    status     = ST_ACCEPTED;
                  end
                end else if (file_end) begin
                  phase_next = PH_MAGIC;
                  status     = ST_LONE_TAG;
                end else if (word == TAG_FUNC) begin
                  phase_next = PH_LENSKIP;
                end else if (word == TAG_COUNTERS) begin
                  phase_next = PH_CTRLEN;
                end else if (tag_known) begin
                  phase_next = PH_LENSKIP;
                end else begin
                  status   = ST_UNKNOWN_TAG;
                  err_next = 1'b1;
                end
              end
              PH_LENSKIP: begin
                if (word == '0) begin
                  phase_next = PH_TAG;
                  if (file_end) begin
                    phase_next = PH_MAGIC;
                    status     = ST_ACCEPTED;
                  end
                end else if (file_end) begin
                  phase_next = PH_MAGIC;
                  status     = ST_OVERRUN;
                end else begin
                  skip_next  = word;
                  phase_next = PH_SKIP;
                end
              end
              PH_CTRLEN: begin
                if (word[0]) begin
                  status = ST_ODD_LENGTH;
                  if (file_end) phase_next = PH_MAGIC;
                  else err_next = 1'b1;
                end else begin
                  cnt_next = cnt + {1'b0, half_len};
                  if (half_len == '0) begin
                    phase_next = PH_TAG;
                    if (file_end) begin
                      phase_next = PH_MAGIC;
                      status     = ST_ACCEPTED;
                    end
                  end else begin
                    pairs_next = half_len;
                    if (file_end) begin
                      phase_next = PH_MAGIC;
                      status     = ST_IN_COUNTERS;
                    end else begin
                      phase_next = PH_CTRLO;
                    end
                  end
                end
              end
              PH_CTRLO: begin
                if (file_end) begin
                  phase_next = PH_MAGIC;
                  status     = ST_OVERRUN;
                end else begin
                  low_half_next = word;
                  lo_pos_next   = msb_pos32(word);
                  lo_nz_next    = (word != '0);
                  phase_next    = PH_CTRHI;
                end
              end
              PH_CTRHI: begin
                req.insert = 1'b1;
                req.idx    = ins_idx;
                req.value  = value;
                sum_next   = sum + value;
                if (less_signed(largest, value)) largest_next = value;
                pairs_next = pairs_dec;
                if (pairs_dec == '0) begin
                  phase_next = PH_TAG;
                  if (file_end) begin
                    phase_next = PH_MAGIC;
                    status     = ST_ACCEPTED;
                  end
                end else if (file_end) begin
                  phase_next = PH_MAGIC;
                  status     = ST_IN_COUNTERS;
                end else begin
                  phase_next = PH_CTRLO;
                end
              end
              default: phase_next = PH_MAGIC;
            endcase
          end
        end
        OP_READ: begin
          req.read = 1'b1;
          req.idx  = bucket_index;
        end
        OP_CLEAR: begin
          clear_all    = 1'b1;
          cnt_next     = '0;
          sum_next     = '0;
          largest_next = '0;
        end
        default: ;
      endcase
    end
    res.status      = status;
    res.total_count = cnt_next;
    res.total_sum   = sum_next;
    res.max_value   = largest_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_MAGIC;
      skip     <= '0;
      pairs    <= '0;
      low_half <= '0;
      lo_pos   <= '0;
      lo_nz    <= 1'b0;
      err      <= 1'b0;
      cnt      <= '0;
      sum      <= '0;
      largest  <= '0;
    end else begin
      phase    <= phase_next;
      skip     <= skip_next;
      pairs    <= pairs_next;
      low_half <= low_half_next;
      lo_pos   <= lo_pos_next;
      lo_nz    <= lo_nz_next;
      err      <= err_next;
      cnt      <= cnt_next;
      sum      <= sum_next;
      largest  <= largest_next;
    end
  end

endmodule

### rtl/pcsh_bucket_store.sv
// bucket memory with registered read, read-modify-write and forwarding
module pcsh_bucket_store
  import pcsh_pkg::*;
#(
  parameter int NUM_BUCKETS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       clear_all,
  input  store_req_t req,
  output bucket_t    rd_data
);

  localparam int IDX_W = $clog2(NUM_BUCKETS);
  localparam logic [BUCKET_IDX_W:0] IDX_LIMIT = (BUCKET_IDX_W+1)'(NUM_BUCKETS);

  bucket_t mem [NUM_BUCKETS];
  bucket_t rd_q;
  logic [NUM_BUCKETS-1:0] used;

  logic             b_insert;
  logic             b_in_range;
  logic [IDX_W-1:0] b_idx;
  logic [VAL_W-1:0] b_value;

  logic             last_wr;
  logic [IDX_W-1:0] last_idx;
  bucket_t          last_data;

  logic       a_in_range;
  bucket_t    cur;
  bucket_t    old;
  bucket_t    upd;
  logic       live;
  logic       wr_en;

  assign a_in_range = ({1'b0, req.idx} < IDX_LIMIT);

  assign cur   = (last_wr && last_idx == b_idx) ? last_data : rd_q;
  assign live  = b_in_range && used[b_idx];
  assign old   = live ? cur : bucket_t'{tally: '0, least: MIN_EMPTY, total: '0};
  assign wr_en = b_insert && b_in_range;

  always_comb begin
    upd.tally = old.tally + 32'd1;
    upd.total = old.total + b_value;
    upd.least = less_signed(b_value, old.least) ? b_value : old.least;
  end

  assign rd_data = old;

  always_ff @(posedge clk) begin
    rd_q <= mem[req.idx[IDX_W-1:0]];
    if (wr_en) begin
      mem[b_idx] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    b_idx      <= req.idx[IDX_W-1:0];
    b_value    <= req.value;
    b_in_range <= a_in_range;
    last_idx   <= b_idx;
    last_data  <= upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_insert <= 1'b0;
      last_wr  <= 1'b0;
      used     <= '0;
    end else begin
      b_insert <= req.insert;
      last_wr  <= wr_en;
      if (clear_all) begin
        used <= '0;
      end else if (wr_en) begin
        used[b_idx] <= 1'b1;
      end
    end
  end

endmodule

### rtl/pcsh_out_fifo.sv
// three-entry result queue in front of the output channel
module pcsh_out_fifo
  import pcsh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [OUT_DATA_W-1:0] din,
  input  logic                  ready,
  output logic                  valid,
  output logic [OUT_DATA_W-1:0] dout,
  output logic [LEVEL_W-1:0]    level
);

  logic [OUT_DATA_W-1:0] slots [FIFO_DEPTH];
  logic [LEVEL_W-1:0]    wr_ptr, rd_ptr;
  logic                  pop;

  assign valid = (level != '0);
  assign dout  = slots[rd_ptr];
  assign pop   = valid && ready;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LEVEL_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LEVEL_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      level <= level + LEVEL_W'(push) - LEVEL_W'(pop);
    end
  end

endmodule

### rtl/profile_counter_stream_histogram.sv
// top level of the profile counter stream histogram
//
// channel  dir  tdata                      tuser   tlast
// s_*      in   word, bucket_index         opcode  file_end
// m_*      out  status, totals, bucket     -       -
//
// one item per cycle while s_tready is high; one result per item, registered into the result queue
// totals update in the accept cycle; bucket read-modify-write registers the
// memory read, then writes the update, same-bucket back-to-back updates are forwarded
// rst clears parse state, totals and all bucket used flags at once
// a three-entry result queue absorbs output stalls; s_tready drops when full
module profile_counter_stream_histogram
  import pcsh_pkg::*;
#(
  parameter int NUM_BUCKETS = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [IN_DATA_W-1:0]    s_tdata,  // word, bucket_index
  input  logic [OPCODE_W-1:0]     s_tuser,  // opcode
  input  logic                    s_tlast,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OUT_DATA_W-1:0]   m_tdata   // status, total_count, total_sum, max_value,
                                            // bucket_count, bucket_min, bucket_sum, zero pad
);

  logic        accept;
  store_req_t  req;
  logic        clear_all;
  parse_res_t  res;
  bucket_t     rd_data;

  logic        b_valid;
  logic        b_is_read;
  parse_res_t  b_res;

  logic [OUT_DATA_W-1:0] out_item;
  bucket_t               out_bucket;
  logic [LEVEL_W-1:0]    level;
  logic [LEVEL_W:0]      occupancy;

  assign occupancy = {1'b0, level} + (LEVEL_W+1)'(b_valid);
  assign s_tready  = (occupancy < (LEVEL_W+1)'(FIFO_DEPTH));
  assign accept    = s_tvalid && s_tready;

  pcsh_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .opcode       (s_tuser),
    .word         (s_tdata[WORD_W-1:0]),
    .file_end     (s_tlast),
    .bucket_index (s_tdata[WORD_W +: BUCKET_IDX_W]),
    .req          (req),
    .clear_all    (clear_all),
    .res          (res)
  );

  pcsh_bucket_store #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .clear_all (clear_all),
    .req       (req),
    .rd_data   (rd_data)
  );

  always_ff @(posedge clk) begin
    b_res <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      b_is_read <= 1'b0;
    end else begin
      b_valid   <= accept;
      b_is_read <= accept && (s_tuser == OP_READ);
    end
  end

  assign out_bucket = b_is_read ? rd_data : '0;
  assign out_item   = {4'h0, out_bucket.total, out_bucket.least, out_bucket.tally,
                       b_res.max_value, b_res.total_sum, b_res.total_count, b_res.status};

  pcsh_out_fifo u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (b_valid),
    .din   (out_item),
    .ready (m_tready),
    .valid (m_tvalid),
    .dout  (m_tdata),
    .level (level)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(b_valid && level == LEVEL_W'(FIFO_DEPTH)))
    else $error("result queue overflow");

  a_read_tracks: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser == OP_READ |=> b_valid && b_is_read)
    else $error("bucket read lost in pipeline");

  a_read_status_ok: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_is_read |-> b_res.status == ST_OK)
    else $error("bucket read with parser status");

  a_result_queued: assert property (@(posedge clk) disable iff (rst)
    b_valid |=> m_tvalid)
    else $error("result not queued");

endmodule

### bench/testbench.sv
// self-checking testbench for the profile counter stream histogram
module testbench;
  import pcsh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [WORD_W-1:0]   word;
    logic                last;
    logic [7:0]          idx;
  } stim_t;

  // top field first, so status lands in the low bits as on m_tdata
  typedef struct packed {
    logic [63:0] bucket_sum;
    logic [63:0] bucket_min;
    logic [31:0] bucket_count;
    logic [63:0] max_value;
    logic [63:0] total_sum;
    logic [31:0] total_count;
    logic [3:0]  status;
  } hist_res_t;

  typedef struct packed {
    stim_t       stim;
    logic        known;
    logic [3:0]  want_status;
    logic [63:0] want_min;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [OPCODE_W-1:0]   s_tuser = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int send_idle = 24;
  int recv_idle = 53;
  int errors = 0;
  int items_sent = 0;
  int files_sent = 0;
  int results_checked = 0;
  int cycle_count = 0;
  logic [15:0] status_seen = '0;

  hist_res_t expected_results [$];

  // parser and histogram state of the predictor
  phase_t      p_phase;
  logic [32:0] p_skip;
  logic [30:0] p_pairs;
  logic [31:0] p_low;
  logic        p_err;
  logic [31:0] p_count;
  logic [63:0] p_sum;
  logic [63:0] p_max;
  logic        h_used  [256];
  logic [31:0] h_tally [256];
  logic [63:0] h_least [256];
  logic [63:0] h_total [256];
  logic [7:0]  hot_bucket = '0;

  // known rows all come while the store is still empty
  dir_row_t dir_table [24] = '{
    '{'{OP_READ,   32'hffff_ffff, 1'b1, 8'hff}, 1'b1, ST_OK,          MIN_EMPTY},
    '{'{OP_NOP,    32'hffff_ffff, 1'b1, 8'hff}, 1'b1, ST_OK,          64'h0},
    '{'{OP_STREAM, 32'h0,         1'b0, 8'h00}, 1'b1, ST_BAD_MAGIC,   64'h0},
    '{'{OP_STREAM, 32'hffff_ffff, 1'b1, 8'hff}, 1'b1, ST_DROPPED,     64'h0},
    '{'{OP_STREAM, FILE_MAGIC,    1'b1, 8'h00}, 1'b1, ST_OVERRUN,     64'h0},
    '{'{OP_STREAM, FILE_MAGIC,    1'b0, 8'hff}, 1'b1, ST_OK,          64'h0},
    '{'{OP_STREAM, 32'hffff_ffff, 1'b0, 8'h00}, 1'b1, ST_OK,          64'h0},
    '{'{OP_STREAM, 32'h0,         1'b0, 8'hff}, 1'b1, ST_OK,          64'h0},
    '{'{OP_STREAM, 32'h0,         1'b0, 8'h00}, 1'b1, ST_OK,          64'h0},
    '{'{OP_STREAM, TAG_FUNC,      1'b0, 8'hff}, 1'b1, ST_OK,          64'h0},
    '{'{OP_STREAM, 32'h1,         1'b0, 8'h00}, 1'b1, ST_OK,          64'h0},
    '{'{OP_STREAM, 32'hffff_ffff, 1'b0, 8'hff}, 1'b1, ST_OK,          64'h0},
    '{'{OP_STREAM, 32'h01b1_0000, 1'b0, 8'h00}, 1'b1, ST_OK,          64'h0},
    '{'{OP_STREAM, 32'h0,         1'b0, 8'hff}, 1'b1, ST_OK,          64'h0},
    '{'{OP_STREAM, TAG_COUNTERS,  1'b0, 8'h00}, 1'b1, ST_OK,          64'h0},
    '{'{OP_STREAM, 32'h6,         1'b0, 8'hff}, 1'b0, ST_OK,          64'h0},
    '{'{OP_STREAM, 32'hffff_ffff, 1'b0, 8'h00}, 1'b0, ST_OK,          64'h0},
    '{'{OP_STREAM, 32'h7fff_ffff, 1'b0, 8'hff}, 1'b0, ST_OK,          64'h0},
    '{'{OP_STREAM, 32'h0,         1'b0, 8'h00}, 1'b0, ST_OK,          64'h0},
    '{'{OP_STREAM, 32'h8000_0000, 1'b0, 8'hff}, 1'b0, ST_OK,          64'h0},
    '{'{OP_STREAM, 32'h3,         1'b0, 8'h00}, 1'b0, ST_OK,          64'h0},
    '{'{OP_STREAM, 32'h0,         1'b1, 8'hff}, 1'b0, ST_OK,          64'h0},
    '{'{OP_CLEAR,  32'hffff_ffff, 1'b0, 8'h00}, 1'b0, ST_OK,          64'h0},
    '{'{OP_READ,   32'h0,         1'b0, 8'hfb}, 1'b1, ST_OK,          MIN_EMPTY}
  };

  profile_counter_stream_histogram #(
    .NUM_BUCKETS(256)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),   // word, bucket_index
    .s_tuser (s_tuser),   // opcode
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)    // status, total_count, total_sum, max_value,
                          // bucket_count, bucket_min, bucket_sum, zero pad
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic void clear_hist();
    p_count = '0;
    p_sum = '0;
    p_max = '0;
    foreach (h_used[i]) h_used[i] = 1'b0;
  endfunction

  function automatic logic [7:0] log_bucket(input logic [63:0] v);
    int r;
    r = 0;
    for (int i = 0; i < 64; i++) if (v[i]) r = i;
    if (r < 2) return v[7:0];
    return 8'((r - 1) * 4) + 8'(v[r-1 -: 2]);
  endfunction

  function automatic logic [3:0] abort_file(input logic [3:0] code, input logic last);
    if (last) p_phase = PH_MAGIC;
    else p_err = 1'b1;
    return code;
  endfunction

  function automatic logic [3:0] finish_or_busy(input logic last);
    if (last) begin
      p_phase = PH_MAGIC;
      return ST_ACCEPTED;
    end
    return ST_OK;
  endfunction

  function automatic logic [3:0] parse_word(input logic [31:0] w, input logic last);
    logic [31:0] d;
    logic [63:0] v;
    logic [7:0]  b;
    d = w - TAG_COUNTERS;
    v = {w, p_low};
    if (p_err) begin
      if (last) begin
        p_err = 1'b0;
        p_phase = PH_MAGIC;
      end
      return ST_DROPPED;
    end
    case (p_phase)
      PH_MAGIC: begin
        if (w != FILE_MAGIC) return abort_file(ST_BAD_MAGIC, last);
        if (last) return abort_file(ST_OVERRUN, 1'b1);
        p_skip = 33'd2;
        p_phase = PH_SKIP;
        return ST_OK;
      end
      PH_SKIP: begin
        if (p_skip != 0) p_skip = p_skip - 1;
        if (p_skip == 0) begin
          p_phase = PH_TAG;
          return finish_or_busy(last);
        end
        if (last) return abort_file(ST_OVERRUN, 1'b1);
        return ST_OK;
      end
      PH_TAG: begin
        if (w == 0) return finish_or_busy(last);
        if (last) return abort_file(ST_LONE_TAG, 1'b1);
        if (w == TAG_FUNC) p_phase = PH_LENSKIP;
        else if (w == TAG_COUNTERS) p_phase = PH_CTRLEN;
        else if (w[15:0] == 16'h0 && (d >> TAG_SHIFT) < TAG_SPAN) p_phase = PH_LENSKIP;
        else return abort_file(ST_UNKNOWN_TAG, 1'b0);
        return ST_OK;
      end
      PH_LENSKIP: begin
        if (w == 0) begin
          p_phase = PH_TAG;
          return finish_or_busy(last);
        end
        if (last) return abort_file(ST_OVERRUN, 1'b1);
        p_skip = {1'b0, w};
        p_phase = PH_SKIP;
        return ST_OK;
      end
      PH_CTRLEN: begin
        if (w[0]) return abort_file(ST_ODD_LENGTH, last);
        p_count = p_count + (w >> 1);
        if (w == 0) begin
          p_phase = PH_TAG;
          return finish_or_busy(last);
        end
        p_pairs = 31'(w >> 1);
        if (last) return abort_file(ST_IN_COUNTERS, 1'b1);
        p_phase = PH_CTRLO;
        return ST_OK;
      end
      PH_CTRLO: begin
        if (last) return abort_file(ST_OVERRUN, 1'b1);
        p_low = w;
        p_phase = PH_CTRHI;
        return ST_OK;
      end
      PH_CTRHI: begin
        // bucket numbers never exceed 251, so every counter lands in the store
        b = log_bucket(v);
        if (!h_used[b]) begin
          h_used[b] = 1'b1;
          h_tally[b] = '0;
          h_least[b] = MIN_EMPTY;
          h_total[b] = '0;
        end
        h_tally[b] = h_tally[b] + 1;
        h_total[b] = h_total[b] + v;
        if ($signed(v) < $signed(h_least[b])) h_least[b] = v;
        hot_bucket = b;
        p_sum = p_sum + v;
        if ($signed(p_max) < $signed(v)) p_max = v;
        if (p_pairs != 0) p_pairs = p_pairs - 1;
        if (p_pairs == 0) begin
          p_phase = PH_TAG;
          return finish_or_busy(last);
        end
        if (last) return abort_file(ST_IN_COUNTERS, 1'b1);
        p_phase = PH_CTRLO;
        return ST_OK;
      end
      default: begin
        p_phase = PH_MAGIC;
        return ST_OK;
      end
    endcase
  endfunction

  function automatic hist_res_t step_profile(input stim_t it);
    hist_res_t r;
    r = '0;
    case (it.op)
      OP_STREAM: r.status = parse_word(it.word, it.last);
      OP_READ: begin
        r.bucket_min = MIN_EMPTY;
        if (h_used[it.idx]) begin
          r.bucket_count = h_tally[it.idx];
          r.bucket_min = h_least[it.idx];
          r.bucket_sum = h_total[it.idx];
        end
      end
      OP_CLEAR: clear_hist();
      default: ;
    endcase
    r.total_count = p_count;
    r.total_sum = p_sum;
    r.max_value = p_max;
    return r;
  endfunction

  function automatic stim_t word_item(input logic [31:0] w);
    return '{OP_STREAM, w, 1'b0, 8'($urandom_range(255))};
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  task automatic send_item(input stim_t it, input logic known, input hist_res_t want);
    hist_res_t pred;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {it.idx, it.word};
    s_tuser  <= it.op;
    s_tlast  <= it.last;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    pred = step_profile(it);
    status_seen[pred.status] = 1'b1;
    expected_results.insert(expected_results.size(), known ? want : pred);
    items_sent++;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_file();
    stim_t       words [$];
    stim_t       side;
    logic [63:0] v;
    logic [31:0] w;
    int          k;
    int          len;
    int          cut;
    words.insert(words.size(), word_item(FILE_MAGIC));
    words.insert(words.size(), word_item($urandom));
    words.insert(words.size(), word_item($urandom));
    repeat ($urandom_range(4)) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          k = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(3);
          words.insert(words.size(), word_item(TAG_COUNTERS));
          words.insert(words.size(), word_item(32'(2 * k)));
          repeat (k) begin
            v = {$urandom, $urandom};
            case ($urandom_range(3))
              0: v = v >> $urandom_range(63);
              1: v = v & 64'hf;
              2: v = -(v >> $urandom_range(63));
              default: ;
            endcase
            words.insert(words.size(), word_item(v[31:0]));
            words.insert(words.size(), word_item(v[63:32]));
          end
        end
        6, 7: begin
          w = ($urandom_range(1) == 0) ? TAG_FUNC
                                       : TAG_COUNTERS + ($urandom_range(1, 8) << TAG_SHIFT);
          len = $urandom_range(3);
          words.insert(words.size(), word_item(w));
          words.insert(words.size(), word_item(32'(len)));
          repeat (len) words.insert(words.size(), word_item($urandom));
        end
        default: words.insert(words.size(), word_item(32'h0));
      endcase
    end
    // broken file: corrupt a word, cut the file short, or both
    if ($urandom_range(3) == 0) begin
      cut = $urandom_range(words.size() - 1);
      if ($urandom_range(1) == 0) begin
        case ($urandom_range(5))
          0: words[cut].word = $urandom;
          1: words[cut].word = $urandom | 32'h1;
          2: words[cut].word = $urandom & 32'hffff_0000;
          3: words[cut].word = 32'h0;
          4: words[cut].word = TAG_COUNTERS;
          default: words[cut].word = FILE_MAGIC;
        endcase
        cut = $urandom_range(cut, words.size() - 1);
      end
      while (words.size() > cut + 1) void'(words.pop_back());
    end
    words[words.size() - 1].last = 1'b1;
    foreach (words[i]) begin
      k = $urandom_range(199);
      if (k < 18) begin
        side.op = (k < 16) ? OP_READ : (k == 16) ? OP_CLEAR : OP_NOP;
        side.word = $urandom;
        side.last = 1'($urandom_range(1));
        side.idx = ($urandom_range(1) == 0) ? 8'($urandom_range(255)) : hot_bucket;
        send_item(side, 1'b0, '0);
      end
      send_item(words[i], 1'b0, '0);
    end
    files_sent++;
  endtask

  always @(negedge clk) begin : result_check
    hist_res_t got;
    hist_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = hist_res_t'(m_tdata[$bits(hist_res_t)-1:0]);
      if (expected_results.size() == 0) begin
        $error("result with no item waiting: %h", got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("total_count", 64'(want.total_count), 64'(got.total_count));
        check_field("total_sum", want.total_sum, got.total_sum);
        check_field("max_value", want.max_value, got.max_value);
        check_field("bucket_count", 64'(want.bucket_count), 64'(got.bucket_count));
        check_field("bucket_min", want.bucket_min, got.bucket_min);
        check_field("bucket_sum", want.bucket_sum, got.bucket_sum);
        results_checked++;
      end
    end
  end

  initial begin : main
    hist_res_t want;
    p_phase = PH_MAGIC;
    p_skip = '0;
    p_pairs = '0;
    p_low = '0;
    p_err = 1'b0;
    clear_hist();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_table[i]) begin
      want = '0;
      want.status = dir_table[i].want_status;
      want.bucket_min = dir_table[i].want_min;
      send_item(dir_table[i].stim, dir_table[i].known, want);
    end
    wait_drained();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 24 : (ph == 1) ? 53 : 0;
      recv_idle = (ph == 0) ? 53 : (ph == 1) ? 24 : 0;
      while (items_sent < (ph + 1) * 500 + 24) begin
        send_file();
        if ($urandom_range(29) == 0) wait_drained();
      end
      wait_drained();
    end
    repeat (10) @(posedge clk);
    $display("covered %0d items in %0d profile files, %0d results compared",
             items_sent, files_sent, results_checked);
    $display("%0d of 9 status codes predicted, three stall mixes on both sides",
             $countones(status_seen));
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
